// ===== hw/rtl/hfdc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hfdc_pkg: shared types and helpers of the header field delta classifier
// Token state, table entry types, segment type codes and the per-character
// token update.
// ---------------------------------------------------------------------------
package hfdc_pkg;

  localparam int unsigned MaxFieldsDef = 64;
  localparam int unsigned FidxW        = 6;
  localparam int unsigned ValW         = 64;
  localparam int unsigned SegW         = 4;

  // segment type codes (the "less than" code of each but ST_STR is one higher)
  localparam logic [SegW-1:0] ST_DGT     = 4'd0;
  localparam logic [SegW-1:0] ST_STR     = 4'd2;
  localparam logic [SegW-1:0] ST_HGT     = 4'd3;
  localparam logic [SegW-1:0] ST_HEX_LZ  = 4'd5;
  localparam logic [SegW-1:0] ST_HGTC    = 4'd7;
  localparam logic [SegW-1:0] ST_HEXU_LZ = 4'd9;
  localparam logic [SegW-1:0] ST_DEC_LZ  = 4'd11;

  // letter case codes
  localparam logic [1:0] CASE_NONE  = 2'd0;
  localparam logic [1:0] CASE_LOWER = 2'd1;
  localparam logic [1:0] CASE_UPPER = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_FOLD  = 8'h20;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef struct packed {
    logic [ValW-1:0] dec_accum;
    logic [ValW-1:0] hex_accum;
    logic            lead_zero;
    logic [1:0]      letter_case;
    logic            only_digits;
    logic            is_text;
    logic            at_second;
  } tok_t;

  localparam tok_t TOK_RESET = '{
    dec_accum:   '0,
    hex_accum:   '0,
    lead_zero:   1'b0,
    letter_case: CASE_NONE,
    only_digits: 1'b1,
    is_text:     1'b0,
    at_second:   1'b0
  };

  typedef struct packed {
    logic            hex;
    logic [ValW-1:0] value;
  } tbl_data_t;

  typedef struct packed {
    logic      valid;
    tbl_data_t data;
  } tbl_entry_t;

  typedef struct packed {
    logic             en;
    logic [FidxW-1:0] idx;
    logic             keep;
    tbl_data_t        data;
  } tbl_wr_t;

  // one character into the running token state
  function automatic tok_t take_char(tok_t cur, logic [7:0] c, logic first);
    tok_t       t;
    logic [7:0] lc;
    logic [1:0] want;
    t    = cur;
    lc   = c | CH_FOLD;
    want = (c >= CH_LA) ? CASE_LOWER : CASE_UPPER;
    if (first) begin
      t           = TOK_RESET;
      t.lead_zero = (c == CH_ZERO);
      t.at_second = 1'b1;
    end else if (t.at_second) begin
      if (t.lead_zero && (c == CH_ZERO)) t.is_text = 1'b1;
      t.at_second = 1'b0;
    end
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      t.dec_accum = (t.dec_accum << 3) + (t.dec_accum << 1)
                  + {{(ValW-8){1'b0}}, c - CH_ZERO};
      t.hex_accum = (t.hex_accum << 4) + {{(ValW-8){1'b0}}, c - CH_ZERO};
    end else if ((lc >= CH_LA) && (lc <= CH_LF)) begin
      t.only_digits = 1'b0;
      if ((t.letter_case != CASE_NONE) && (t.letter_case != want)) t.is_text = 1'b1;
      t.letter_case = want;
      t.hex_accum   = (t.hex_accum << 4) + {{(ValW-8){1'b0}}, lc - CH_LA + HEX_TEN};
    end else begin
      t.only_digits = 1'b0;
      t.is_text     = 1'b1;
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/header_field_delta_classifier.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// header_field_delta_classifier: top level
// Classifies changed header field tokens and gives type and delta per field.
// ---------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one request per beat: a token character, or with
//    tuser high a clear of the field table and token state (character and marks ignored).
//  - tlast marks the last character of a token; only then is a result made.
//  - Master stream carries one result per token: segment type and gap.
//  - One request accepted per cycle while tready is high, tokens may end on every cycle.
//  - Pipeline: the table read register loads as the last character is taken,
//    the result register loads from it once free; tvalid is high from then on.
//  - The table read register also serves as a second slot, so a request is
//    still taken while one result waits on a stalled receiver; with both
//    slots full tready drops until the receiver takes a result.
//  - Reset clears the token state, the pipeline and every table valid bit at
//    once; there is no clearing pass, values behind a clear bit are ignored.
//  - Fields at or beyond MAX_FIELDS see no previous value and are never stored.
// ---------------------------------------------------------------------------
module header_field_delta_classifier #(
  parameter int unsigned MAX_FIELDS = hfdc_pkg::MaxFieldsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // ch[7:0], field_index[13:8], first_char[14]
  input  logic        s_axis_tuser_i,   // req_type
  input  logic        s_axis_tlast_i,   // last_char
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // type code[3:0], gap[67:4]
);

  localparam int unsigned FidxW = hfdc_pkg::FidxW;
  localparam int unsigned ValW  = hfdc_pkg::ValW;
  localparam int unsigned SegW  = hfdc_pkg::SegW;

  // request unpack
  logic [7:0]       ch;
  logic [FidxW-1:0] field_index;
  logic             first_char;
  assign ch          = s_axis_tdata_i[7:0];
  assign field_index = s_axis_tdata_i[13:8];
  assign first_char  = s_axis_tdata_i[14];

  // handshake
  logic acc, chr_acc, clr_acc, tok_end;
  logic out_en;
  logic s1_v_q, out_v_q;

  assign out_en          = s1_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_v_q || out_en;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign chr_acc         = acc && !s_axis_tuser_i;
  assign clr_acc         = acc && s_axis_tuser_i;
  assign tok_end         = chr_acc && s_axis_tlast_i;

  // token accumulation
  hfdc_pkg::tok_t tok_now;

  hfdc_token u_token (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .chr_i   (chr_acc),
    .clr_i   (clr_acc),
    .ch_i    (ch),
    .first_i (first_char),
    .last_i  (s_axis_tlast_i),
    .tok_o   (tok_now)
  );

  // stage 1: finished token, table entry read alongside
  hfdc_pkg::tok_t   s1_tok_q;
  logic [FidxW-1:0] s1_idx_q;
  logic             s1_in_tbl_q;
  logic             in_table;

  // widen by one bit so MAX_FIELDS itself fits in the compare
  assign in_table = ({1'b0, field_index} < (FidxW + 1)'(MAX_FIELDS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (tok_end) begin
      s1_v_q <= 1'b1;
    end else if (out_en) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_end) begin
      s1_tok_q    <= tok_now;
      s1_idx_q    <= field_index;
      s1_in_tbl_q <= in_table;
    end
  end

  // field table; written as stage 1 retires into the result register
  hfdc_pkg::tbl_entry_t entry;
  hfdc_pkg::tbl_wr_t    tbl_wr;
  logic                 keep;
  hfdc_pkg::tbl_data_t  wr_data;
  logic [SegW-1:0]      seg_code;
  logic [ValW-1:0]      gap;

  assign tbl_wr = '{en: out_en && s1_in_tbl_q, idx: s1_idx_q, keep: keep, data: wr_data};

  hfdc_table #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (tok_end),
    .rd_idx_i (field_index),
    .wr_i     (tbl_wr),
    .clr_i    (clr_acc),
    .entry_o  (entry)
  );

  hfdc_resolve u_resolve (
    .tok_i      (s1_tok_q),
    .entry_i    (entry),
    .in_table_i (s1_in_tbl_q),
    .seg_code_o (seg_code),
    .gap_o      (gap),
    .keep_o     (keep),
    .data_o     (wr_data)
  );

  // result register
  logic [SegW-1:0] out_type_q;
  logic [ValW-1:0] out_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_type_q <= seg_code;
      out_gap_q  <= gap;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {4'b0000, out_gap_q, out_type_q};

endmodule

// ===== hw/rtl/hfdc_token.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hfdc_token: running token state
// Folds each character into the decimal and hex accumulators and flags;
// returns to the reset state after a last character or a clear.
// ---------------------------------------------------------------------------
module hfdc_token (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                chr_i,      // character request taken
  input  logic                clr_i,      // clear request taken
  input  logic [7:0]          ch_i,
  input  logic                first_i,
  input  logic                last_i,
  output hfdc_pkg::tok_t      tok_o       // state including this character
);

  hfdc_pkg::tok_t tok_q, tok_d;

  always_comb begin
    tok_o = hfdc_pkg::take_char(tok_q, ch_i, first_i);
    tok_d = tok_q;
    if (clr_i || (chr_i && last_i)) begin
      tok_d = hfdc_pkg::TOK_RESET;
    end else if (chr_i) begin
      tok_d = tok_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= hfdc_pkg::TOK_RESET;
    end else begin
      tok_q <= tok_d;
    end
  end

endmodule

// ===== hw/rtl/hfdc_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hfdc_table: per-field kind and value store
// Value memory with registered read, one valid bit per field in flops
// (cleared at once), and bypass of a write landing on the read edge.
// ---------------------------------------------------------------------------
module hfdc_table #(
  parameter int unsigned MAX_FIELDS = hfdc_pkg::MaxFieldsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [hfdc_pkg::FidxW-1:0]    rd_idx_i,
  input  hfdc_pkg::tbl_wr_t             wr_i,
  input  logic                          clr_i,
  output hfdc_pkg::tbl_entry_t          entry_o
);

  localparam int unsigned IdxW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

  logic [MAX_FIELDS-1:0] valid_q, valid_d;
  hfdc_pkg::tbl_data_t   mem_q [MAX_FIELDS];
  logic                  ent_valid_q;
  hfdc_pkg::tbl_data_t   ent_data_q;
  logic                  hit;
  logic [IdxW-1:0]       widx, ridx;

  assign widx = wr_i.idx[IdxW-1:0];
  assign ridx = rd_idx_i[IdxW-1:0];
  assign hit  = wr_i.en && (wr_i.idx == rd_idx_i);

  always_comb begin
    valid_d = valid_q;
    if (wr_i.en) valid_d[widx] = wr_i.keep;
    if (clr_i)   valid_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      ent_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (rd_en_i) begin
        ent_valid_q <= hit ? wr_i.keep : valid_q[ridx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[widx] <= wr_i.data;
    if (rd_en_i) ent_data_q <= hit ? wr_i.data : mem_q[ridx];
  end

  assign entry_o = '{valid: ent_valid_q, data: ent_data_q};

endmodule

// ===== hw/rtl/hfdc_resolve.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hfdc_resolve: token classification and gap
// Picks the segment type and value, compares with the previous value and
// forms the table update.
// ---------------------------------------------------------------------------
module hfdc_resolve (
  input  hfdc_pkg::tok_t                 tok_i,
  input  hfdc_pkg::tbl_entry_t           entry_i,
  input  logic                           in_table_i,
  output logic [hfdc_pkg::SegW-1:0]      seg_code_o,
  output logic [hfdc_pkg::ValW-1:0]      gap_o,
  output logic                           keep_o,   // field holds a number
  output hfdc_pkg::tbl_data_t            data_o
);

  logic                          has_prev, prev_hex;
  logic [hfdc_pkg::SegW-1:0]     base_type;
  logic [hfdc_pkg::ValW-1:0]     val, prev;
  logic                          use_hex;

  assign has_prev = in_table_i && entry_i.valid;
  assign prev_hex = has_prev && entry_i.data.hex;
  assign prev     = has_prev ? entry_i.data.value : '0;
  assign use_hex  = prev_hex || !tok_i.only_digits;

  always_comb begin
    if (!use_hex) begin
      base_type = tok_i.lead_zero ? hfdc_pkg::ST_DEC_LZ : hfdc_pkg::ST_DGT;
    end else if (tok_i.letter_case == hfdc_pkg::CASE_UPPER) begin
      base_type = tok_i.lead_zero ? hfdc_pkg::ST_HEXU_LZ : hfdc_pkg::ST_HGTC;
    end else begin
      base_type = tok_i.lead_zero ? hfdc_pkg::ST_HEX_LZ : hfdc_pkg::ST_HGT;
    end
    val = use_hex ? tok_i.hex_accum : tok_i.dec_accum;

    if (tok_i.is_text) begin
      seg_code_o = hfdc_pkg::ST_STR;
      gap_o      = '0;
    end else if (val < prev) begin
      seg_code_o = base_type + 4'd1;
      gap_o      = prev - val;
    end else begin
      seg_code_o = base_type;
      gap_o      = val - prev;
    end
  end

  assign keep_o = !tok_i.is_text;
  assign data_o = '{hex: use_hex, value: val};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for header_field_delta_classifier
// A queue of requests (token characters and table clears) feeds a clocked
// stream driver. Each accepted request goes through a cycle-free model of the
// token classifier and field table, and the expected segment type and gap are
// queued. A clocked monitor compares every result beat with the oldest one.
// Both sides idle at random; the receiver holds off once for a long stretch,
// and the sender drains the pipeline at marked points in the request stream.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RAND_REQS = 1050;
  localparam int unsigned LIMIT     = 200000;
  localparam int unsigned HOLD_AT   = 1000;
  localparam int unsigned HOLD_LEN  = 250;
  localparam int unsigned DRAIN_CYC = 10;
  localparam int unsigned SegW      = hfdc_pkg::SegW;
  localparam int unsigned ValW      = hfdc_pkg::ValW;

  typedef enum logic [1:0] {FK_NONE, FK_DEC, FK_HEX} fkind_e;

  typedef struct packed {
    logic       drain;   // marker: wait for every result before going on
    logic       clr;
    logic [7:0] ch;
    logic [5:0] fidx;
    logic       first;
    logic       last;
  } req_t;

  typedef struct packed {
    logic [SegW-1:0] seg;
    logic [ValW-1:0] gap;
  } seg_res_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [71:0] m_tdata;

  // model state
  fkind_e          fld_kind [64];
  logic [ValW-1:0] fld_value [64];
  logic [ValW-1:0] tok_dec, tok_hex;
  logic            tok_lz, tok_digits, tok_text, tok_second;
  logic [1:0]      tok_case;

  req_t     pending_reqs [$];
  seg_res_t results_due [$];
  req_t     cur_req;
  int       n_due_made = 0;   // driver side, blocking
  int       n_seen     = 0;   // monitor side, nonblocking
  int       n_taken    = 0;
  int       n_errors   = 0;
  int       cycles     = 0;
  int       hold_left  = 0;
  logic     drv_go, drv_valid;

  header_field_delta_classifier DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --- model -----------------------------------------------------------------

  task automatic tok_restart();
    tok_dec    = '0;
    tok_hex    = '0;
    tok_lz     = 1'b0;
    tok_case   = hfdc_pkg::CASE_NONE;
    tok_digits = 1'b1;
    tok_text   = 1'b0;
    tok_second = 1'b0;
  endtask

  task automatic table_wipe();
    for (int i = 0; i < 64; i++) begin
      fld_kind[i]  = FK_NONE;
      fld_value[i] = '0;
    end
    tok_restart();
  endtask

  // one accepted request; queues the result it causes, if any
  task automatic classify_request(input req_t r);
    logic [7:0]      lc, dg, hv;
    logic [1:0]      want;
    fkind_e          kind;
    logic [SegW-1:0] seg;
    logic [ValW-1:0] val, prev;
    seg_res_t        res;
    lc = r.ch | 8'h20;
    dg = r.ch - 8'h30;
    hv = lc - 8'h61 + 8'd10;
    if (r.clr) begin
      table_wipe();
      return;
    end
    if (r.first) begin
      tok_restart();
      tok_lz     = (r.ch == 8'h30);
      tok_second = 1'b1;
    end else if (tok_second) begin
      // a second zero after a leading zero makes it text
      if (tok_lz && r.ch == 8'h30) tok_text = 1'b1;
      tok_second = 1'b0;
    end
    if (r.ch >= 8'h30 && r.ch <= 8'h39) begin
      tok_dec = tok_dec * 64'd10 + dg;
      tok_hex = (tok_hex << 4) + dg;
    end else if (lc >= 8'h61 && lc <= 8'h66) begin
      want       = (r.ch >= 8'h61) ? hfdc_pkg::CASE_LOWER : hfdc_pkg::CASE_UPPER;
      tok_digits = 1'b0;
      if (tok_case != hfdc_pkg::CASE_NONE && tok_case != want) tok_text = 1'b1;
      tok_case = want;
      tok_hex  = (tok_hex << 4) + hv;
    end else begin
      tok_digits = 1'b0;
      tok_text   = 1'b1;
    end
    if (!r.last) return;

    kind = fld_kind[r.fidx];
    if (tok_text) begin
      fld_kind[r.fidx] = FK_NONE;   // value kept
      res.seg = hfdc_pkg::ST_STR;
      res.gap = '0;
    end else begin
      // stored hex kind overrides the decimal reading of an all-digit token
      if (kind != FK_HEX && tok_digits) begin
        seg = tok_lz ? hfdc_pkg::ST_DEC_LZ : hfdc_pkg::ST_DGT;
        val = tok_dec;
      end else if (tok_case == hfdc_pkg::CASE_UPPER) begin
        seg = tok_lz ? hfdc_pkg::ST_HEXU_LZ : hfdc_pkg::ST_HGTC;
        val = tok_hex;
      end else begin
        seg = tok_lz ? hfdc_pkg::ST_HEX_LZ : hfdc_pkg::ST_HGT;
        val = tok_hex;
      end
      prev = (kind != FK_NONE) ? fld_value[r.fidx] : '0;
      fld_kind[r.fidx]  = (seg < hfdc_pkg::ST_STR || seg >= hfdc_pkg::ST_DEC_LZ) ? FK_DEC
                                                                                 : FK_HEX;
      fld_value[r.fidx] = val;
      if (val < prev) begin
        res.seg = seg + 1'b1;
        res.gap = prev - val;
      end else begin
        res.seg = seg;
        res.gap = val - prev;
      end
    end
    results_due.push_back(res);
    n_due_made++;
    tok_restart();
  endtask

  // --- request list helpers ---------------------------------------------------

  task automatic add_req(input logic clr, input logic [7:0] ch, input logic [5:0] fidx,
                         input logic first, input logic last);
    req_t r;
    r = '{drain: 1'b0, clr: clr, ch: ch, fidx: fidx, first: first, last: last};
    pending_reqs.push_back(r);
  endtask

  task automatic add_drain();
    req_t r;
    r       = '0;
    r.drain = 1'b1;
    pending_reqs.push_back(r);
  endtask

  task automatic add_token(input logic [5:0] fidx, input string s);
    for (int i = 0; i < s.len(); i++)
      add_req(1'b0, s[i], fidx, i == 0, i == s.len() - 1);
  endtask

  task automatic report_mismatch(input string what, input logic [ValW-1:0] got,
                                 input logic [ValW-1:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  // --- stimulus -----------------------------------------------------------------

  initial begin
    string      digs_l, digs_u;
    int         n_rand, style, len, junk_at, next_drain;
    logic [5:0] fidx;
    logic [7:0] c;
    digs_l = "0123456789abcdef";
    digs_u = "0123456789ABCDEF";
    table_wipe();

    // directed part
    add_req(1'b1, 8'hA5, 6'h2A, 1'b1, 1'b1);   // clear, other fields ignored
    add_token(6'd0, "0");                       // lone zero: zero-led decimal
    add_token(6'd1, "00");                      // double zero: text
    add_token(6'd2, "9");
    add_token(6'd2, "3");                       // decimal going down
    add_token(6'd3, "ff");
    add_token(6'd3, "0a");                      // zero-led hex lower, down
    add_token(6'd4, "AB");
    add_token(6'd4, "0A");                      // zero-led hex upper, down
    add_token(6'd5, "aB");                      // mixed case: text
    add_req(1'b0, 8'hFF, 6'd63, 1'b1, 1'b1);    // non-hex byte, top field
    add_token(6'd3, "99");                      // digits read as hex on hex field
    add_req(1'b0, "5", 6'd6, 1'b0, 1'b1);       // no first mark
    add_req(1'b0, "1", 6'd7, 1'b1, 1'b0);
    add_req(1'b1, 8'h00, 6'd7, 1'b0, 1'b0);     // clear mid-token
    add_req(1'b0, "2", 6'd7, 1'b0, 1'b1);
    add_token(6'd2, "0");                       // zero-led decimal, down
    add_drain();

    // random part: mostly well-formed tokens on a few hot fields
    n_rand     = 0;
    next_drain = 300;
    while (n_rand < RAND_REQS) begin
      if (n_rand >= next_drain) begin
        add_drain();
        next_drain += 500;
      end
      style = $urandom_range(0, 99);
      if (style < 4) begin
        add_req(1'b1, 8'($urandom), 6'($urandom), 1'($urandom), 1'($urandom));
        n_rand++;
      end else if (style < 9) begin
        add_req(1'b0, 8'($urandom), 6'($urandom), 1'($urandom), 1'($urandom));
        n_rand++;
      end else begin
        fidx    = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 7))
                                              : 6'($urandom_range(0, 63));
        len     = ($urandom_range(0, 14) == 0) ? $urandom_range(15, 22)
                                               : $urandom_range(1, 6);
        junk_at = ($urandom_range(0, 14) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          if (style < 40)
            c = digs_l[$urandom_range(0, 9)];
          else if (style < 65)
            c = digs_l[$urandom_range(0, 15)];
          else if (style < 85)
            c = digs_u[$urandom_range(0, 15)];
          else
            c = ($urandom_range(0, 1) != 0) ? digs_l[$urandom_range(0, 15)]
                                            : digs_u[$urandom_range(0, 15)];
          // leading zero now and then, a double one more rarely
          if (i == 0 && $urandom_range(0, 5) == 0) c = "0";
          if (i == 1 && pending_reqs[$].ch == "0" && $urandom_range(0, 7) == 0) c = "0";
          if (i == junk_at) c = 8'($urandom);
          add_req(1'b0, c, fidx, i == 0, i == len - 1);
          n_rand++;
        end
      end
    end
  end

  // reset once
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  // --- sender -------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
      s_tlast  <= 1'b0;
    end else begin
      drv_go = !s_tvalid || s_tready;
      if (s_tvalid && s_tready) begin
        classify_request(cur_req);
        n_taken++;
      end
      if (drv_go) begin
        drv_valid = 1'b0;
        if (pending_reqs.size() != 0 && pending_reqs[0].drain) begin
          if (n_due_made == n_seen) void'(pending_reqs.pop_front());
        end else if (pending_reqs.size() != 0 &&
                     ((n_taken >= 100 && n_taken < 250) || $urandom_range(0, 99) >= 36)) begin
          cur_req   = pending_reqs.pop_front();
          drv_valid = 1'b1;
          s_tdata   <= {1'b0, cur_req.first, cur_req.fidx, cur_req.ch};
          s_tuser   <= cur_req.clr;
          s_tlast   <= cur_req.last;
        end
        s_tvalid <= drv_valid;
      end
    end
  end

  // --- receiver: random back-pressure, one long hold-off ------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (cycles == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= (cycles >= 400 && cycles < 800) || ($urandom_range(0, 99) >= 36);
    end
  end

  // --- result checker -------------------------------------------------------------

  always @(posedge clk_i) begin
    seg_res_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[ValW-1:0], '0);
      end else begin
        want = results_due.pop_front();
        if (m_tdata[3:0] !== want.seg)
          report_mismatch("type code", m_tdata[3:0], want.seg);
        if (m_tdata[67:4] !== want.gap)
          report_mismatch("gap", m_tdata[67:4], want.gap);
        n_seen <= n_seen + 1;
      end
    end
  end

  // --- cycle count and timeout ------------------------------------------------------

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --- end of run -------------------------------------------------------------------

  initial begin
    @(posedge rst_ni);
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_tvalid || n_due_made != n_seen);
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (n_errors == 0 && results_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== header_field_delta_classifier.f =====
hw/rtl/hfdc_pkg.sv
hw/rtl/hfdc_token.sv
hw/rtl/hfdc_table.sv
hw/rtl/hfdc_resolve.sv
hw/rtl/header_field_delta_classifier.sv
tb/tb_top.sv
